>>> design/clcd_pkg.sv
// Shared types, codes and the power-up command list for the character LCD nibble writer.
package clcd_pkg;

    // Request codes
    localparam logic [1:0] ACT_DATA = 2'd0;
    localparam logic [1:0] ACT_CMD  = 2'd1;
    localparam logic [1:0] ACT_GOTO = 2'd2;
    localparam logic [1:0] ACT_INIT = 2'd3;

    // Panel layouts
    localparam logic [1:0] GEOM_16X2 = 2'd0;
    localparam logic [1:0] GEOM_16X4 = 2'd1;
    localparam logic [1:0] GEOM_20X4 = 2'd2;

    // Result item kinds
    localparam logic KIND_PIN   = 1'b0;
    localparam logic KIND_DELAY = 1'b1;

    // Commands at or below this value need the long settle time
    localparam logic [7:0] CMD_SLOW_MAX = 8'h02;
    localparam logic [2:0] SLOW_WAIT_MS = 3'd2;

    // Power-up list length and default request queue depth
    localparam int INIT_OPS    = 12;
    localparam int QUEUE_DEPTH = 2;

    localparam int OP_IDX_W = $clog2(INIT_OPS);

    typedef struct packed {
        logic       init;
        logic       rs;
        logic [7:0] byte_val;
    } clcd_job_t;

    typedef struct packed {
        logic       is_delay;
        logic [7:0] cmd;
        logic [2:0] wait_ms;
        logic       last;
    } clcd_op_t;

    // DDRAM base address of a row for the given layout
    function automatic logic [7:0] row_base(input logic [1:0] geom, input logic [1:0] row);
        logic [7:0] base;
        base = 8'hC0;
        if (row == 2'd0) begin
            base = 8'h80;
        end else if (geom inside {GEOM_16X4, GEOM_20X4}) begin
            case (row)
                2'd1:    base = 8'hC0;
                2'd2:    base = (geom == GEOM_16X4) ? 8'h90 : 8'h94;
                default: base = (geom == GEOM_16X4) ? 8'hD0 : 8'hD4;
            endcase
        end
        return base;
    endfunction

    // Power-up list: byte or wait, one entry per step
    function automatic clcd_op_t init_op(input logic [OP_IDX_W-1:0] idx);
        clcd_op_t op;
        op = '{is_delay: 1'b0, cmd: 8'h00, wait_ms: 3'd0, last: 1'b0};
        case (idx)
            4'd0:    op.cmd = 8'h30;
            4'd1:    begin op.is_delay = 1'b1; op.wait_ms = 3'd5; end
            4'd2:    op.cmd = 8'h30;
            4'd3:    begin op.is_delay = 1'b1; op.wait_ms = 3'd1; end
            4'd4:    op.cmd = 8'h30;
            4'd5:    op.cmd = 8'h02;
            4'd6:    begin op.is_delay = 1'b1; op.wait_ms = SLOW_WAIT_MS; end
            4'd7:    op.cmd = 8'h28;
            4'd8:    op.cmd = 8'h0C;
            4'd9:    op.cmd = 8'h06;
            4'd10:   op.cmd = 8'h01;
            default: begin
                op.is_delay = 1'b1;
                op.wait_ms  = SLOW_WAIT_MS;
                op.last     = 1'b1;
            end
        endcase
        return op;
    endfunction

    // Step idx of a request: the power-up list, or one byte and an optional settle wait
    function automatic clcd_op_t op_at(input clcd_job_t job, input logic [OP_IDX_W-1:0] idx);
        clcd_op_t op;
        logic     slow;
        slow = !job.rs && (job.byte_val <= CMD_SLOW_MAX);
        if (job.init) begin
            op = init_op(idx);
        end else if (idx == '0) begin
            op = '{is_delay: 1'b0, cmd: job.byte_val, wait_ms: 3'd0, last: !slow};
        end else begin
            op = '{is_delay: 1'b1, cmd: 8'h00, wait_ms: SLOW_WAIT_MS, last: 1'b1};
        end
        return op;
    endfunction

endpackage

>>> design/clcd_front.sv
// Request front end: geometry register, request decode and queue push.
module clcd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_action,
    input  logic [7:0]        s_byte_value,
    input  logic [4:0]        s_column,
    input  logic [1:0]        s_row,
    input  logic              q_full,
    output logic              q_push,
    output clcd_pkg::clcd_job_t q_job
);

    logic [1:0] geometry_reg;
    logic [1:0] geometry_next;

    always_comb begin
        geometry_next = cfg_wr_en ? cfg_wr_data : geometry_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geometry_reg <= clcd_pkg::GEOM_16X2;
        end else begin
            geometry_reg <= geometry_next;
        end
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_job = '{init: 1'b0, rs: 1'b0, byte_val: s_byte_value};
        case (s_action)
            clcd_pkg::ACT_DATA: q_job.rs = 1'b1;
            clcd_pkg::ACT_CMD:  q_job.rs = 1'b0;
            clcd_pkg::ACT_GOTO: begin
                // set DDRAM address: row base plus column, wraps at 8 bits
                q_job.byte_val = clcd_pkg::row_base(geometry_reg, s_row) + {3'b000, s_column};
            end
            default:            q_job.init = 1'b1;
        endcase
    end

endmodule

>>> design/clcd_queue.sv
// Small request queue between the front end and the nibble sequencer.
module clcd_queue #(
    parameter int DEPTH = clcd_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  clcd_pkg::clcd_job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output clcd_pkg::clcd_job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    clcd_pkg::clcd_job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_push_moves_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push without pop did not grow the queue");
`endif

endmodule

>>> design/clcd_back.sv
// Nibble sequencer: queued requests to pin and wait items, one per unstalled cycle.
module clcd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  clcd_pkg::clcd_job_t q_job,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_kind,
    output logic              m_reg_select,
    output logic              m_enable,
    output logic [3:0]        m_nibble,
    output logic [2:0]        m_wait_ms,
    output logic              m_last
);

    localparam int IDX_W = clcd_pkg::OP_IDX_W;

    logic                busy_reg, busy_next;
    clcd_pkg::clcd_job_t job_reg, job_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [1:0]          phase_reg, phase_next;
    logic                m_valid_reg, m_valid_next;

    logic       m_kind_reg, m_reg_select_reg, m_enable_reg, m_last_reg;
    logic [3:0] m_nibble_reg;
    logic [2:0] m_wait_ms_reg;

    clcd_pkg::clcd_op_t op;
    logic               load_out, emit, item_last, op_done;

    assign op        = clcd_pkg::op_at(job_reg, idx_reg);
    assign load_out  = !m_valid_reg || m_ready;
    assign emit      = busy_reg && load_out;
    assign op_done   = op.is_delay || (phase_reg == 2'd3);
    assign item_last = op.last && op_done;
    assign q_pop     = q_valid && (!busy_reg || (emit && item_last));

    always_comb begin
        busy_next    = busy_reg;
        job_next     = job_reg;
        idx_next     = idx_reg;
        phase_next   = phase_reg;
        m_valid_next = load_out ? emit : m_valid_reg;
        if (emit) begin
            if (item_last) begin
                busy_next = 1'b0;
            end else if (op_done) begin
                idx_next   = idx_reg + 1'b1;
                phase_next = 2'd0;
            end else begin
                phase_next = phase_reg + 1'b1;
            end
        end
        if (q_pop) begin
            busy_next  = 1'b1;
            job_next   = q_job;
            idx_next   = '0;
            phase_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            phase_reg   <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            idx_reg     <= idx_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        job_reg <= job_next;
        if (emit) begin
            m_last_reg <= item_last;
            if (op.is_delay) begin
                m_kind_reg       <= clcd_pkg::KIND_DELAY;
                m_reg_select_reg <= 1'b0;
                m_enable_reg     <= 1'b0;
                m_nibble_reg     <= 4'h0;
                m_wait_ms_reg    <= op.wait_ms;
            end else begin
                m_kind_reg       <= clcd_pkg::KIND_PIN;
                m_reg_select_reg <= job_reg.rs && !job_reg.init;
                m_enable_reg     <= !phase_reg[0];
                m_nibble_reg     <= phase_reg[1] ? op.cmd[3:0] : op.cmd[7:4];
                m_wait_ms_reg    <= 3'd0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_reg_select = m_reg_select_reg;
    assign m_enable     = m_enable_reg;
    assign m_nibble     = m_nibble_reg;
    assign m_wait_ms    = m_wait_ms_reg;
    assign m_last       = m_last_reg;

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg <= IDX_W'(clcd_pkg::INIT_OPS - 1)))
        else $error("sequencer step beyond power-up list");

    a_strobe_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && (m_kind == clcd_pkg::KIND_PIN) && m_enable)
        |=> (m_valid && (m_kind == clcd_pkg::KIND_PIN) && !m_enable
             && (m_nibble == $past(m_nibble))))
        else $error("enable high not followed by matching enable low");

    a_last_strobe_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> !m_enable)
        else $error("request ended with enable high");

    a_delay_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_kind == clcd_pkg::KIND_DELAY))
        |-> (!m_enable && !m_reg_select && (m_nibble == 4'h0) && (m_wait_ms != 3'd0)))
        else $error("wait item carries pin levels");
`endif

endmodule

>>> design/char_lcd_nibble_writer_core.sv
// Top level of the character LCD 4-bit nibble writer.
// Turns LCD requests (data byte, command byte, cursor go-to, power-up init) into
// a stream of pin-level transactions for a 4-bit HD44780-style bus: each byte
// goes out high nibble first, each nibble as an enable-high then enable-low
// item, and a wait item follows slow commands (0x00..0x02) and the fixed
// power-up waits. The sequencer puts out one item per clock while m_ready does
// not stall it; a data or fast command request is 4 items, a slow command 5, a
// go-to 4 (a row base plus column never falls in the slow range), and the
// power-up sequence 36; the single-item output register sets the rate.
// Requests are taken while earlier ones are still going out, up to QUEUE_DEPTH
// waiting in the queue; a request taken into an idle block goes to the queue,
// then to the sequencer, then its first item to the output register. Geometry
// is sampled when a request is taken; write it only while the block is idle.
module char_lcd_nibble_writer_core #(
    parameter int QUEUE_DEPTH = clcd_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    // request channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [7:0] s_byte_value,
    input  logic [4:0] s_column,
    input  logic [1:0] s_row,
    // item channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic       m_reg_select,
    output logic       m_enable,
    output logic [3:0] m_nibble,
    output logic [2:0] m_wait_ms,
    output logic       m_last
);

    // front end to queue
    logic                q_full;
    logic                q_push;
    clcd_pkg::clcd_job_t q_push_job;

    // queue to sequencer
    logic                q_pop;
    logic                q_valid;
    clcd_pkg::clcd_job_t q_pop_job;

    // decode and geometry lookup
    clcd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_byte_value (s_byte_value),
        .s_column     (s_column),
        .s_row        (s_row),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (q_push_job)
    );

    // decouples request intake from item output
    clcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (q_push_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_job   (q_pop_job)
    );

    // nibble/strobe sequencer with registered output
    clcd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_job        (q_pop_job),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_reg_select (m_reg_select),
        .m_enable     (m_enable),
        .m_nibble     (m_nibble),
        .m_wait_ms    (m_wait_ms),
        .m_last       (m_last)
    );

endmodule

>>> tb/tb.sv
// Self-checking testbench for the character LCD 4-bit nibble writer core.
`timescale 1ns / 100ps

module tb;

    localparam int  HALF_PERIOD    = 6;
    localparam int  RESET_CYCLES   = 6;
    localparam int  CYCLE_LIMIT    = 2_000_000;
    localparam int  END_SETTLE     = 12;
    localparam int  MAX_BURST      = 36;
    localparam int  REPORT_MAX     = 10;
    localparam int  PHASE_REQUESTS = 76;

    // Layout code that the panel table does not define; it must act as 16x2
    localparam logic [1:0] GEOM_UNUSED = 2'd3;

    // Power-up command bytes and waits
    localparam logic [7:0] LCD_WAKE        = 8'h30;
    localparam logic [7:0] LCD_HOME        = 8'h02;
    localparam logic [7:0] LCD_FUNC_4BIT   = 8'h28;
    localparam logic [7:0] LCD_DISPLAY_ON  = 8'h0C;
    localparam logic [7:0] LCD_ENTRY_INC   = 8'h06;
    localparam logic [7:0] LCD_CLS         = 8'h01;
    localparam logic [2:0] WAKE_FIRST_MS   = 3'd5;
    localparam logic [2:0] WAKE_SECOND_MS  = 3'd1;

    // DDRAM row start addresses
    localparam logic [7:0] ROW0_ADDR       = 8'h80;
    localparam logic [7:0] ROW1_ADDR       = 8'hC0;
    localparam logic [7:0] ROW2_ADDR_16    = 8'h90;
    localparam logic [7:0] ROW3_ADDR_16    = 8'hD0;
    localparam logic [7:0] ROW2_ADDR_20    = 8'h94;
    localparam logic [7:0] ROW3_ADDR_20    = 8'hD4;

    typedef struct packed {
        logic       kind;
        logic       rs;
        logic       en;
        logic [3:0] nibble;
        logic [2:0] wait_ms;
        logic       last;
    } lcd_item_t;

    typedef struct {
        logic [1:0] action;
        logic [7:0] byte_val;
        logic [4:0] column;
        logic [1:0] row;
        bit         drain_first;  // hold this request back until the bus has gone quiet
    } lcd_req_t;

    // ---------------------------------------------------------------------------
    // DUT ports, inputs at known values from time zero
    // ---------------------------------------------------------------------------
    logic       aclk         = 1'b0;
    logic       aresetn      = 1'b0;
    logic       cfg_wr_en    = 1'b0;
    logic [1:0] cfg_wr_data  = 2'd0;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic [1:0] s_action     = 2'd0;
    logic [7:0] s_byte_value = 8'd0;
    logic [4:0] s_column     = 5'd0;
    logic [1:0] s_row        = 2'd0;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    logic       m_kind;
    logic       m_reg_select;
    logic       m_enable;
    logic [3:0] m_nibble;
    logic [2:0] m_wait_ms;
    logic       m_last;

    char_lcd_nibble_writer_core u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_byte_value (s_byte_value),
        .s_column     (s_column),
        .s_row        (s_row),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_reg_select (m_reg_select),
        .m_enable     (m_enable),
        .m_nibble     (m_nibble),
        .m_wait_ms    (m_wait_ms),
        .m_last       (m_last)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // ---------------------------------------------------------------------------
    // Testbench state
    // ---------------------------------------------------------------------------
    lcd_req_t  req_pending [$];   // requests waiting for the driver
    lcd_item_t lcd_items_due [$]; // expected bus items, oldest first
    lcd_req_t  req_on_bus;        // request currently held on the input channel
    lcd_item_t burst [MAX_BURST]; // items of the request being expanded
    int        burst_len;
    logic [1:0] panel_geom = clcd_pkg::GEOM_16X2; // mirror of the layout register

    int src_gap, src_calm, sink_gap, sink_calm;
    int fault_count, items_checked, cycle_count;
    int action_count [4];
    bit layout_used [4];

    // ---------------------------------------------------------------------------
    // Predictor: expands one request into the bus items it must produce
    // ---------------------------------------------------------------------------
    task automatic add_item(input logic kind, input logic rs, input logic en,
                            input logic [3:0] nibble, input logic [2:0] wait_ms);
        burst[burst_len] = '{kind, rs, en, nibble, wait_ms, 1'b0};
        burst_len++;
    endtask

    // One byte: high nibble then low nibble, each strobed E high then E low.
    // Slow commands (clear, home and anything below) need a settle wait after.
    task automatic add_byte(input logic is_data, input logic [7:0] value);
        add_item(clcd_pkg::KIND_PIN, is_data, 1'b1, value[7:4], 3'd0);
        add_item(clcd_pkg::KIND_PIN, is_data, 1'b0, value[7:4], 3'd0);
        add_item(clcd_pkg::KIND_PIN, is_data, 1'b1, value[3:0], 3'd0);
        add_item(clcd_pkg::KIND_PIN, is_data, 1'b0, value[3:0], 3'd0);
        if (!is_data && value <= clcd_pkg::CMD_SLOW_MAX) begin
            add_item(clcd_pkg::KIND_DELAY, 1'b0, 1'b0, 4'd0, clcd_pkg::SLOW_WAIT_MS);
        end
    endtask

    // Start address of a row; undefined layouts and rows past a 2-line panel
    // fall back to the 16x2 map (row 0 at 0x80, everything else at 0xC0)
    function automatic logic [7:0] cursor_row_start(input logic [1:0] geom,
                                                    input logic [1:0] row);
        logic [7:0] start;
        if (row == 2'd0) begin
            start = ROW0_ADDR;
        end else if (row == 2'd1) begin
            start = ROW1_ADDR;
        end else if (geom == clcd_pkg::GEOM_16X4) begin
            start = (row == 2'd2) ? ROW2_ADDR_16 : ROW3_ADDR_16;
        end else if (geom == clcd_pkg::GEOM_20X4) begin
            start = (row == 2'd2) ? ROW2_ADDR_20 : ROW3_ADDR_20;
        end else begin
            start = ROW1_ADDR;
        end
        return start;
    endfunction

    task automatic expand_lcd_request(input lcd_req_t req);
        burst_len = 0;
        case (req.action)
            clcd_pkg::ACT_DATA: add_byte(1'b1, req.byte_val);
            clcd_pkg::ACT_CMD:  add_byte(1'b0, req.byte_val);
            // Address wraps to 8 bits; columns past the panel go out as they are
            clcd_pkg::ACT_GOTO: begin
                add_byte(1'b0, 8'(cursor_row_start(panel_geom, req.row) + req.column));
            end
            default: begin
                add_byte(1'b0, LCD_WAKE);
                add_item(clcd_pkg::KIND_DELAY, 1'b0, 1'b0, 4'd0, WAKE_FIRST_MS);
                add_byte(1'b0, LCD_WAKE);
                add_item(clcd_pkg::KIND_DELAY, 1'b0, 1'b0, 4'd0, WAKE_SECOND_MS);
                add_byte(1'b0, LCD_WAKE);
                add_byte(1'b0, LCD_HOME);
                add_byte(1'b0, LCD_FUNC_4BIT);
                add_byte(1'b0, LCD_DISPLAY_ON);
                add_byte(1'b0, LCD_ENTRY_INC);
                add_byte(1'b0, LCD_CLS);
            end
        endcase
        burst[burst_len-1].last = 1'b1;
        for (int i = 0; i < burst_len; i++) begin
            lcd_items_due.push_back(burst[i]);
        end
    endtask

    // Mostly back-to-back, some short gaps, now and then a long one
    function automatic int draw_gap(input int calm);
        int pick;
        pick = $urandom_range(0, 99);
        if (calm > 0 || pick < 55) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 20);
        end
    endfunction

    task automatic report_fault(input string what);
        fault_count++;
        if (fault_count <= REPORT_MAX) begin
            $display("[%0t] ERROR: %s", $realtime, what);
        end
    endtask

    // ---------------------------------------------------------------------------
    // Request driver: one transaction held on the bus until accepted
    // ---------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expand_lcd_request(req_on_bus);
                action_count[req_on_bus.action]++;
            end
            // Only touch the channel when nothing is left waiting on it
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (req_pending.size() > 0 &&
                             (!req_pending[0].drain_first || lcd_items_due.size() == 0)) begin
                    req_on_bus    = req_pending.pop_front();
                    s_action     <= req_on_bus.action;
                    s_byte_value <= req_on_bus.byte_val;
                    s_column     <= req_on_bus.column;
                    s_row        <= req_on_bus.row;
                    s_valid      <= 1'b1;
                    if (src_calm > 0) begin
                        src_calm--;
                    end else if ($urandom_range(0, 39) == 0) begin
                        src_calm = $urandom_range(20, 60);
                    end
                    src_gap = draw_gap(src_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------------
    // Item monitor: back-pressure and in-order comparison
    // ---------------------------------------------------------------------------
    always @(posedge aclk) begin
        lcd_item_t seen, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                seen = '{m_kind, m_reg_select, m_enable, m_nibble, m_wait_ms, m_last};
                items_checked++;
                if (lcd_items_due.size() == 0) begin
                    report_fault($sformatf({"unexpected item kind=%0d rs=%0d e=%0d d=%h ",
                                            "ms=%0d last=%0d"},
                                           seen.kind, seen.rs, seen.en, seen.nibble,
                                           seen.wait_ms, seen.last));
                end else begin
                    want = lcd_items_due.pop_front();
                    if (seen !== want) begin
                        report_fault($sformatf({"item %0d: expected kind=%0d rs=%0d e=%0d d=%h ",
                                                "ms=%0d last=%0d, got kind=%0d rs=%0d e=%0d ",
                                                "d=%h ms=%0d last=%0d"},
                                               items_checked, want.kind, want.rs, want.en,
                                               want.nibble, want.wait_ms, want.last,
                                               seen.kind, seen.rs, seen.en, seen.nibble,
                                               seen.wait_ms, seen.last));
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (sink_calm > 0) begin
                    sink_calm--;
                end else if ($urandom_range(0, 49) == 0) begin
                    sink_calm = $urandom_range(30, 100);
                end
                sink_gap = draw_gap(sink_calm);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items still due",
                     cycle_count, lcd_items_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------------
    task automatic add_request(input logic [1:0] action, input logic [7:0] byte_val,
                               input logic [4:0] column, input logic [1:0] row,
                               input bit drain_first);
        lcd_req_t r;
        r = '{action, byte_val, column, row, drain_first};
        req_pending.push_back(r);
    endtask

    task automatic queue_random_requests(input int count);
        int         pick;
        logic [1:0] action;
        logic [7:0] byte_val;
        logic [4:0] column;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                action = clcd_pkg::ACT_DATA;
            end else if (pick < 62) begin
                action = clcd_pkg::ACT_CMD;
            end else if (pick < 90) begin
                action = clcd_pkg::ACT_GOTO;
            end else begin
                action = clcd_pkg::ACT_INIT;
            end
            byte_val = 8'($urandom);
            // Lean on the slow-command boundary
            if (action == clcd_pkg::ACT_CMD && $urandom_range(0, 9) < 3) begin
                byte_val = 8'($urandom_range(0, 3));
            end
            column = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(0, 19));
            add_request(action, byte_val, column, 2'($urandom_range(0, 3)),
                        $urandom_range(0, 59) == 0);
        end
    endtask

    // Blocks until the driver is empty and every expected item has come back
    task automatic wait_for_quiet_bus();
        while (req_pending.size() > 0 || s_valid || lcd_items_due.size() > 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        logic [1:0] layouts [6];
        layouts = '{clcd_pkg::GEOM_16X4, clcd_pkg::GEOM_20X4, GEOM_UNUSED,
                    clcd_pkg::GEOM_16X2, clcd_pkg::GEOM_20X4, clcd_pkg::GEOM_16X4};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset layout (16x2)
        layout_used[panel_geom] = 1'b1;
        add_request(clcd_pkg::ACT_DATA, 8'h00, 5'd0,  2'd0, 1'b0);
        add_request(clcd_pkg::ACT_DATA, 8'hFF, 5'd31, 2'd3, 1'b0);
        add_request(clcd_pkg::ACT_DATA, 8'h5A, 5'd0,  2'd0, 1'b0);
        add_request(clcd_pkg::ACT_CMD,  8'h00, 5'd0,  2'd0, 1'b0); // zero still counts as slow
        add_request(clcd_pkg::ACT_CMD,  8'h01, 5'd0,  2'd0, 1'b0);
        add_request(clcd_pkg::ACT_CMD,  8'h02, 5'd0,  2'd0, 1'b0);
        add_request(clcd_pkg::ACT_CMD,  8'h03, 5'd0,  2'd0, 1'b0); // first fast command
        add_request(clcd_pkg::ACT_CMD,  8'hFF, 5'd0,  2'd0, 1'b0);
        add_request(clcd_pkg::ACT_CMD,  8'hA5, 5'd0,  2'd0, 1'b0);
        add_request(clcd_pkg::ACT_GOTO, 8'h00, 5'd0,  2'd0, 1'b0);
        add_request(clcd_pkg::ACT_GOTO, 8'hFF, 5'd15, 2'd1, 1'b0);
        add_request(clcd_pkg::ACT_GOTO, 8'h00, 5'd19, 2'd2, 1'b0); // row past a 2-line panel
        add_request(clcd_pkg::ACT_GOTO, 8'h00, 5'd31, 2'd3, 1'b0); // column past the panel too
        add_request(clcd_pkg::ACT_INIT, 8'h00, 5'd0,  2'd0, 1'b0);
        add_request(clcd_pkg::ACT_DATA, 8'hA5, 5'd10, 2'd1, 1'b1); // sender waits for a quiet bus
        add_request(clcd_pkg::ACT_INIT, 8'hFF, 5'd31, 2'd3, 1'b0);
        wait_for_quiet_bus();

        // Random phases, one layout each; the register is only written when idle
        foreach (layouts[p]) begin
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= layouts[p];
            @(posedge aclk);
            cfg_wr_en   <= 1'b0;
            panel_geom   = layouts[p];
            layout_used[panel_geom] = 1'b1;
            queue_random_requests(PHASE_REQUESTS);
            wait_for_quiet_bus();
        end

        // Let any stray item show up before closing
        repeat (END_SETTLE) @(posedge aclk);
        if (lcd_items_due.size() > 0) begin
            report_fault($sformatf("%0d items never arrived", lcd_items_due.size()));
        end
        if (fault_count > REPORT_MAX) begin
            $display("%0d further errors not shown", fault_count - REPORT_MAX);
        end

        $display("covered %0d data, %0d command, %0d go-to and %0d power-up requests, %0d items",
                 action_count[clcd_pkg::ACT_DATA], action_count[clcd_pkg::ACT_CMD],
                 action_count[clcd_pkg::ACT_GOTO], action_count[clcd_pkg::ACT_INIT],
                 items_checked);
        $display("layouts exercised: 16x2=%0d 16x4=%0d 20x4=%0d undefined=%0d, %0d cycles",
                 layout_used[clcd_pkg::GEOM_16X2], layout_used[clcd_pkg::GEOM_16X4],
                 layout_used[clcd_pkg::GEOM_20X4], layout_used[GEOM_UNUSED], cycle_count);
        if (fault_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/clcd_pkg.sv
design/clcd_front.sv
design/clcd_queue.sv
design/clcd_back.sv
design/char_lcd_nibble_writer_core.sv
tb/tb.sv
